// ===== src/dvft_pkg.sv =====
// Package for the distinct-value frequency table: widths, defaults, control types.
`default_nettype none
package dvft_pkg;
    localparam int VALUE_W           = 32;
    localparam int OCC_W             = 16;
    localparam int DEF_TABLE_DEPTH   = 32;
    localparam int DEF_COUNT_WIDTH   = 16;

    typedef struct packed {
        logic absorb;  // input word taken this cycle
        logic hit;     // some valid cell holds the input value
        logic shift;   // output word taken, chain moves toward cell 0
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_EMIT   = 2'b10
    } t_state;
endpackage
`default_nettype wire

// ===== src/dvft_if.sv =====
// Stream interfaces for the input and result words of the frequency table.
`default_nettype none
interface dvft_in_if import dvft_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last_value;

    modport source (output valid, output value, output last_value, input ready);
    modport sink (input valid, input value, input last_value, output ready);
endinterface

interface dvft_out_if import dvft_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] distinct_value;
    logic        [OCC_W-1:0]   occurrences;
    logic                      last_entry;
    logic                      overflowed;

    modport source (output valid, output distinct_value, output occurrences,
                    output last_entry, output overflowed, input ready);
    modport sink (input valid, input distinct_value, input occurrences,
                  input last_entry, input overflowed, output ready);
endinterface
`default_nettype wire

// ===== src/distinct_value_frequency_table.sv =====
// Distinct-value frequency table: cell chain that counts values and drains in order.
// Values stream in one word per cycle while the block collects; every cell compares
// the incoming value at once and the first free cell takes a new one. The word with
// last_value set is counted, then input ready drops and the table drains from cell 0,
// one result word per cycle while the sink is ready, the cell chain shifting one
// place per word taken. The block takes input again in the cycle after the word with
// last_entry is taken. New values arriving at a full table are dropped and reported
// through overflowed on every result of the set.
`default_nettype none
module distinct_value_frequency_table import dvft_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dvft_in_if.sink    i_in,
    dvft_out_if.source o_out
);
    t_state                 r_state, n_state;
    logic                   r_overflow, n_overflow;
    t_cell_ctl              w_ctl;
    logic [TABLE_DEPTH:0]   w_valid;
    logic [VALUE_W-1:0]     w_value [TABLE_DEPTH+1];
    logic [COUNT_WIDTH-1:0] w_count [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_match;
    logic                   w_take_in, w_take_out, w_last_out;

    assign w_take_in  = i_in.valid && i_in.ready;
    assign w_take_out = o_out.valid && o_out.ready;
    assign w_last_out = w_take_out && o_out.last_entry;

    assign w_ctl.absorb = w_take_in;
    assign w_ctl.hit    = |w_match;
    assign w_ctl.shift  = w_take_out;

    assign w_valid[TABLE_DEPTH] = 1'b0;
    assign w_value[TABLE_DEPTH] = '0;
    assign w_count[TABLE_DEPTH] = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        dvft_cell #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_value      (i_in.value),
            .i_prev_valid ((k == 0) ? 1'b1 : w_valid[(k == 0) ? 0 : k-1]),
            .i_nb_valid   (w_valid[k+1]),
            .i_nb_value   (w_value[k+1]),
            .i_nb_count   (w_count[k+1]),
            .o_valid      (w_valid[k]),
            .o_value      (w_value[k]),
            .o_count      (w_count[k]),
            .o_match      (w_match[k])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (w_take_in && i_in.last_value) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_last_out) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_comb begin
        n_overflow = r_overflow;
        if (w_last_out) begin
            n_overflow = 1'b0;
        end else if (w_take_in && !w_ctl.hit && w_valid[TABLE_DEPTH-1]) begin
            n_overflow = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_ACCEPT;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    assign i_in.ready           = (r_state == ST_ACCEPT);
    assign o_out.valid          = (r_state == ST_EMIT);
    assign o_out.distinct_value = w_value[0];
    assign o_out.last_entry     = !w_valid[1];
    assign o_out.overflowed     = r_overflow;

    if (COUNT_WIDTH >= OCC_W) begin : g_occ_trunc
        assign o_out.occurrences = w_count[0][OCC_W-1:0];
    end else begin : g_occ_ext
        assign o_out.occurrences = {{(OCC_W-COUNT_WIDTH){1'b0}}, w_count[0]};
    end
endmodule
`default_nettype wire

// ===== src/dvft_cell.sv =====
// One table cell: holds a value and its count, matches, allocates and shifts.
`default_nettype none
module dvft_cell import dvft_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [VALUE_W-1:0]     i_value,
    input  wire logic                   i_prev_valid,
    input  wire logic                   i_nb_valid,
    input  wire logic [VALUE_W-1:0]     i_nb_value,
    input  wire logic [COUNT_WIDTH-1:0] i_nb_count,
    output logic                        o_valid,
    output logic [VALUE_W-1:0]          o_value,
    output logic [COUNT_WIDTH-1:0]      o_count,
    output logic                        o_match
);
    logic                   r_valid, n_valid;
    logic [VALUE_W-1:0]     r_value, n_value;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    assign o_match = r_valid && (r_value == i_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_count = r_count;
        if (i_ctl.shift) begin
            n_valid = i_nb_valid;
            n_value = i_nb_value;
            n_count = i_nb_count;
        end else if (i_ctl.absorb) begin
            if (o_match) begin
                if (r_count != {COUNT_WIDTH{1'b1}}) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end else if (!i_ctl.hit && !r_valid && i_prev_valid) begin
                // first free cell takes the new value
                n_valid = 1'b1;
                n_value = i_value;
                n_count = COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_count = r_count;
endmodule
`default_nettype wire

// ===== src/dvft_checker.sv =====
// Port-level assertions for the distinct-value frequency table, bound to the top level.
`default_nettype none
module dvft_checker import dvft_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_in_last_value,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [OCC_W-1:0] i_out_occurrences,
    input wire logic             i_out_last_entry
);
    a_no_input_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while results are pending");

    a_drain_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last_value) |=> i_out_valid)
        else $error("no result after final input word");

    a_drain_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last_entry) |=> i_out_valid)
        else $error("drain stopped before last entry");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last_entry) |=> (!i_out_valid && i_in_ready))
        else $error("result after last entry");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_occurrences != '0))
        else $error("zero occurrence count");
endmodule

bind distinct_value_frequency_table dvft_checker u_dvft_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_last_value   (i_in.last_value),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_occurrences (o_out.occurrences),
    .i_out_last_entry  (o_out.last_entry)
);
`default_nettype wire

// ===== test/distinct_value_frequency_table_tb.sv =====
// Testbench for the distinct-value frequency table: random and directed data sets checked per word.
`timescale 1ns / 100ps
module distinct_value_frequency_table_tb;
    import dvft_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int COUNT_WIDTH = DEF_COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int IDLE_PCT = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } t_set_word;

    typedef struct {
        logic signed [VALUE_W-1:0] distinct_value;
        logic [OCC_W-1:0]          occurrences;
        logic                      last_entry;
        logic                      overflowed;
    } t_freq_entry;

    logic i_clk;
    logic i_rst_n;

    dvft_in_if  in_bus ();
    dvft_out_if out_bus ();

    distinct_value_frequency_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_set_word   pending_words[$];
    t_freq_entry expected_entries[$];
    t_set_word   drv_word;

    logic signed [VALUE_W-1:0] tab_value [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0]    tab_count [TABLE_DEPTH];
    int                        tab_used;
    bit                        tab_dropped;

    int  words_queued;
    int  words_taken;
    int  error_count;
    int  stall_cycles;
    int  hold_left;
    bit  steady;
    bit  want_hold;
    bit  hold_done;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic count_word(input logic signed [VALUE_W-1:0] v, input logic fin);
        int          k;
        bit          hit;
        t_freq_entry e;
        hit = 1'b0;
        for (k = 0; k < tab_used; k++) begin
            if (!hit && tab_value[k] == v) begin
                hit = 1'b1;
                if (tab_count[k] != COUNT_MAX) tab_count[k]++;
            end
        end
        if (!hit) begin
            if (tab_used < TABLE_DEPTH) begin
                tab_value[tab_used] = v;
                tab_count[tab_used] = COUNT_WIDTH'(1);
                tab_used++;
            end else begin
                tab_dropped = 1'b1;
            end
        end
        if (fin) begin
            for (k = 0; k < tab_used; k++) begin
                e.distinct_value = tab_value[k];
                e.occurrences    = tab_count[k][OCC_W-1:0];
                e.last_entry     = (k == tab_used - 1);
                e.overflowed     = tab_dropped;
                expected_entries = {expected_entries, e};
            end
            tab_used    = 0;
            tab_dropped = 1'b0;
        end
    endtask

    task automatic queue_word(input logic signed [VALUE_W-1:0] v, input logic fin);
        t_set_word w;
        w.value      = v;
        w.last_value = fin;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    task automatic queue_random_set();
        logic signed [VALUE_W-1:0] pool [6];
        logic signed [VALUE_W-1:0] v;
        int                        len;
        int                        n;
        int                        k;
        for (k = 0; k < 6; k++) pool[k] = $urandom();
        pool[$urandom_range(5)] = $urandom_range(1) ? VAL_MIN : VAL_MAX;
        if ($urandom_range(7) == 0) len = $urandom_range(48, 40);
        else len = $urandom_range(10, 1);
        for (n = 0; n < len; n++) begin
            if (len > TABLE_DEPTH) v = (n % 5 == 4) ? pool[$urandom_range(5)] : $urandom();
            else if ($urandom_range(9) < 3) v = $urandom();
            else v = pool[$urandom_range(5)];
            queue_word(v, n == len - 1);
        end
    endtask

    task automatic drain();
        wait (words_taken == words_queued && expected_entries.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (pending_words.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                drv_word = pending_words.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.value      <= drv_word.value;
                in_bus.last_value <= drv_word.last_value;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result sink, with one long hold-off while the block is draining
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_bus.ready <= 1'b0;
        end else if (want_hold && !hold_done && out_bus.valid && pending_words.size() > 0) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_freq_entry e;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                count_word(in_bus.value, in_bus.last_value);
                words_taken++;
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_entries.size() == 0) begin
                    $error("result word with none expected: value %0d count %0d",
                           out_bus.distinct_value, out_bus.occurrences);
                    error_count++;
                end else begin
                    e = expected_entries.pop_front();
                    if (out_bus.distinct_value !== e.distinct_value) begin
                        $error("distinct_value: expected %0d, got %0d",
                               e.distinct_value, out_bus.distinct_value);
                        error_count++;
                    end
                    if (out_bus.occurrences !== e.occurrences) begin
                        $error("occurrences: expected %0d, got %0d",
                               e.occurrences, out_bus.occurrences);
                        error_count++;
                    end
                    if (out_bus.last_entry !== e.last_entry) begin
                        $error("last_entry: expected %0b, got %0b",
                               e.last_entry, out_bus.last_entry);
                        error_count++;
                    end
                    if (out_bus.overflowed !== e.overflowed) begin
                        $error("overflowed: expected %0b, got %0b",
                               e.overflowed, out_bus.overflowed);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("distinct_value_frequency_table_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int k;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.value      = '0;
        in_bus.last_value = 1'b0;
        out_bus.ready     = 1'b0;
        tab_used          = 0;
        tab_dropped       = 1'b0;
        words_queued      = 0;
        words_taken       = 0;
        error_count       = 0;
        stall_cycles      = 0;
        hold_left         = 0;
        steady            = 1'b0;
        want_hold         = 1'b0;
        hold_done         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, repeats, repeat on the final word
        queue_word(VAL_MIN, 1'b0);
        queue_word(VAL_MAX, 1'b0);
        queue_word(0, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(VAL_MIN, 1'b0);
        queue_word(1, 1'b0);
        queue_word(32'sh5555_5555, 1'b0);
        queue_word(32'shaaaa_aaaa, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(VAL_MAX, 1'b1);
        // one-word set
        queue_word(0, 1'b1);
        queue_word(5, 1'b0);
        queue_word(5, 1'b0);
        queue_word(5, 1'b1);
        // full table: hit while full, new words dropped, the final one too
        for (k = 0; k < TABLE_DEPTH; k++) queue_word(k * 32'sh9e37_79b9, 1'b0);
        queue_word(32'sh9e37_79b9, 1'b0);
        queue_word(32'sh0bad_f00d, 1'b0);
        queue_word(32'sh0bad_beef, 1'b1);
        // flag clears on the next set
        queue_word(VAL_MIN, 1'b1);
        drain();

        // no idling on either side
        steady = 1'b1;
        k = words_queued;
        while (words_queued - k < 40) queue_random_set();
        drain();
        steady = 1'b0;

        want_hold = 1'b1;
        while (words_queued - k < 85) queue_random_set();
        drain();
        while (words_queued - k < 125) queue_random_set();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("distinct_value_frequency_table_tb: clean");
        end else begin
            $display("distinct_value_frequency_table_tb: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/dvft_pkg.sv
src/dvft_if.sv
src/dvft_cell.sv
src/distinct_value_frequency_table.sv
src/dvft_checker.sv
test/distinct_value_frequency_table_tb.sv
